// ===== design/jspm_pkg.sv =====
// ============================================================================
// jspm_pkg
// Shared field widths, operation and status codes, slot states and the
// sequencer state type of the job slot pool manager.
// ============================================================================
`default_nettype none

package jspm_pkg;

  // Field widths of the request and response transfers.
  localparam int FUNC_W       = 3;
  localparam int SLOT_ID_W    = 4;
  localparam int PAYLOAD_W    = 32;
  localparam int STATUS_W     = 3;
  localparam int COUNT_W      = 5;
  localparam int SLOT_STATE_W = 2;

  // Operation codes. Codes above clear behave as a query.
  localparam logic [FUNC_W-1:0] FN_ADD      = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DISPATCH = 3'd1;
  localparam logic [FUNC_W-1:0] FN_COMPLETE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_CANCEL   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR    = 3'd4;

  // Response status codes.
  localparam logic [STATUS_W-1:0] STAT_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_FREE      = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NONE_PENDING = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_PENDING  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOT_ACTIVE   = 3'd4;

  // Per-slot state codes held in the state memory.
  localparam logic [SLOT_STATE_W-1:0] SLOT_FREE    = 2'd0;
  localparam logic [SLOT_STATE_W-1:0] SLOT_PENDING = 2'd1;
  localparam logic [SLOT_STATE_W-1:0] SLOT_ACTIVE  = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_ADD,
    S_DISPATCH,
    S_CHECK,
    S_WALK,
    S_UNLINK,
    S_CLEAR,
    S_DONE
  } jspm_state_t;

endpackage

`default_nettype wire

// ===== design/jspm_if.sv =====
// ============================================================================
// jspm_if
// Valid/ready channel interfaces for pool requests and pool responses.
// ============================================================================
`default_nettype none

interface jspm_req_if;
  import jspm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [SLOT_ID_W-1:0] slot_id;
  logic [PAYLOAD_W-1:0] payload;

  modport source (output valid, output func, output slot_id, output payload,
                  input ready);
  modport sink   (input valid, input func, input slot_id, input payload,
                  output ready);
endinterface

interface jspm_rsp_if;
  import jspm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [SLOT_ID_W-1:0] result_id;
  logic [PAYLOAD_W-1:0] result_payload;
  logic [COUNT_W-1:0]   free_count;
  logic [COUNT_W-1:0]   pending_count_out;
  logic [COUNT_W-1:0]   active_count_out;
  logic                 slot_is_free;

  modport source (output valid, output status, output result_id,
                  output result_payload, output free_count,
                  output pending_count_out, output active_count_out,
                  output slot_is_free, input ready);
  modport sink   (input valid, input status, input result_id,
                  input result_payload, input free_count,
                  input pending_count_out, input active_count_out,
                  input slot_is_free, output ready);
endinterface

`default_nettype wire

// ===== design/job_slot_pool_manager_top.sv =====
// ============================================================================
// job_slot_pool_manager_top
// Job slot pool with LIFO free and pending lists kept as links in a memory.
// ============================================================================
// Flow: a request is decoded, then handled in an add, dispatch, check, walk or clear
// state before the response is registered. A failed add or dispatch or an id beyond the
// pool goes from decode straight to the response. Cancel walks the pending list from its
// head to the match, clear walks the whole pending list; each list step is one read of the
// link memory. The next request is taken only after the response is registered.
// After reset a clearing pass builds the free chain before any request is taken.
`default_nettype none

module job_slot_pool_manager_top #(
  parameter int MAX_JOBS = 16
) (
  input wire logic clk,
  input wire logic rst,
  jspm_req_if.sink   req,
  jspm_rsp_if.source rsp
);
  import jspm_pkg::*;

  localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int LW = $clog2(MAX_JOBS + 1);
  localparam int CW = (LW > COUNT_W) ? LW : COUNT_W;
  localparam int XW = (LW > SLOT_ID_W) ? LW : SLOT_ID_W;
  localparam logic [LW-1:0] NIL       = LW'(MAX_JOBS);
  localparam logic [IW-1:0] INIT_LAST = IW'(MAX_JOBS - 1);
  localparam logic [CW-1:0] WALK_MAX  = CW'(MAX_JOBS);

  jspm_state_t state, state_next;

  // Control registers.
  logic [IW-1:0] init_idx;
  logic [LW-1:0] free_head;
  logic [LW-1:0] pending_head;
  logic [CW-1:0] pending_total;
  logic [CW-1:0] active_total;
  logic          out_valid;

  // Request and work registers.
  logic [FUNC_W-1:0]    func_q;
  logic [SLOT_ID_W-1:0] sid_q;
  logic [PAYLOAD_W-1:0] pay_q;
  logic [LW-1:0]        walk_cur;
  logic [LW-1:0]        walk_prev;
  logic [CW-1:0]        walk_n;
  logic [STATUS_W-1:0]  res_status;
  logic [SLOT_ID_W-1:0] res_id;
  logic [PAYLOAD_W-1:0] res_pay;
  logic                 res_free;

  // Response registers.
  logic [STATUS_W-1:0]  out_status;
  logic [SLOT_ID_W-1:0] out_id;
  logic [PAYLOAD_W-1:0] out_pay;
  logic [COUNT_W-1:0]   out_free_cnt;
  logic [COUNT_W-1:0]   out_pend_cnt;
  logic [COUNT_W-1:0]   out_act_cnt;
  logic                 out_is_free;

  // Memory ports.
  logic                    lk_we, st_we, py_we;
  logic [IW-1:0]           lk_wa, st_wa, py_wa;
  logic [IW-1:0]           lk_ra, st_ra, py_ra;
  logic [LW-1:0]           lk_wd, lk_rd;
  logic [SLOT_STATE_W-1:0] st_wd, st_rd;
  logic [PAYLOAD_W-1:0]    py_wd, py_rd;

  logic          accept;
  logic          out_load;
  logic          sid_ok;
  logic [LW-1:0] sid_slot;
  logic          walk_hit;
  logic          walk_end;
  logic          clear_end;

  // Shared decode terms.
  assign accept    = req.valid && req.ready;
  assign out_load  = (state == S_DONE) && (!out_valid || rsp.ready);
  assign sid_ok    = XW'(sid_q) < XW'(MAX_JOBS);
  assign sid_slot  = LW'(sid_q);
  assign walk_hit  = walk_cur == sid_slot;
  assign walk_end  = (walk_cur == NIL) || (walk_n == WALK_MAX);
  assign clear_end = (pending_head == NIL) || (walk_n == WALK_MAX);

  // Link, slot state and payload memories.
  jspm_ram #(.DEPTH(MAX_JOBS), .WIDTH(LW)) u_link (
    .clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd)
  );

  jspm_ram #(.DEPTH(MAX_JOBS), .WIDTH(SLOT_STATE_W)) u_state (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd)
  );

  jspm_ram #(.DEPTH(MAX_JOBS), .WIDTH(PAYLOAD_W)) u_payload (
    .clk(clk), .we(py_we), .waddr(py_wa), .wdata(py_wd), .raddr(py_ra), .rdata(py_rd)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (init_idx == INIT_LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (func_q)
          FN_ADD:      state_next = (free_head == NIL) ? S_DONE : S_ADD;
          FN_DISPATCH: state_next = (pending_head == NIL) ? S_DONE : S_DISPATCH;
          FN_CLEAR:    state_next = S_CLEAR;
          default:     state_next = sid_ok ? S_CHECK : S_DONE;
        endcase
      end
      S_ADD, S_DISPATCH, S_UNLINK: begin
        state_next = S_DONE;
      end
      S_CHECK: begin
        if (func_q == FN_CANCEL && st_rd == SLOT_PENDING) state_next = S_WALK;
        else state_next = S_DONE;
      end
      S_WALK: begin
        if (walk_hit) state_next = S_UNLINK;
        else if (walk_end) state_next = S_DONE;
      end
      S_CLEAR: begin
        if (clear_end) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory port control and request handshake.
  always_comb begin
    req.ready = (state == S_IDLE);
    lk_we = 1'b0;
    lk_wa = '0;
    lk_wd = '0;
    lk_ra = '0;
    st_we = 1'b0;
    st_wa = '0;
    st_wd = SLOT_FREE;
    st_ra = '0;
    py_we = 1'b0;
    py_wa = IW'(free_head);
    py_wd = pay_q;
    py_ra = IW'(pending_head);
    unique case (state)
      S_INIT: begin
        lk_we = 1'b1;
        lk_wa = init_idx;
        lk_wd = LW'(init_idx) + LW'(1);
        st_we = 1'b1;
        st_wa = init_idx;
      end
      S_DECODE: begin
        lk_ra = (func_q == FN_ADD) ? IW'(free_head) : IW'(pending_head);
        st_ra = IW'(sid_q);
      end
      S_ADD: begin
        lk_we = 1'b1;
        lk_wa = IW'(free_head);
        lk_wd = pending_head;
        st_we = 1'b1;
        st_wa = IW'(free_head);
        st_wd = SLOT_PENDING;
        py_we = 1'b1;
      end
      S_DISPATCH: begin
        lk_we = 1'b1;
        lk_wa = IW'(pending_head);
        lk_wd = NIL;
        st_we = 1'b1;
        st_wa = IW'(pending_head);
        st_wd = SLOT_ACTIVE;
      end
      S_CHECK: begin
        // Completing an active job pushes its slot onto the free list.
        lk_ra = IW'(pending_head);
        if (func_q == FN_COMPLETE && st_rd == SLOT_ACTIVE) begin
          lk_we = 1'b1;
          lk_wa = IW'(sid_q);
          lk_wd = free_head;
          st_we = 1'b1;
          st_wa = IW'(sid_q);
        end
      end
      S_WALK: begin
        // Follow the chain; on a match behind the head, bypass the slot.
        lk_ra = IW'(lk_rd);
        if (walk_hit && walk_prev != NIL) begin
          lk_we = 1'b1;
          lk_wa = IW'(walk_prev);
          lk_wd = lk_rd;
        end
      end
      S_UNLINK: begin
        lk_we = 1'b1;
        lk_wa = IW'(sid_q);
        lk_wd = free_head;
        st_we = 1'b1;
        st_wa = IW'(sid_q);
      end
      S_CLEAR: begin
        lk_ra = IW'(lk_rd);
        if (!clear_end) begin
          lk_we = 1'b1;
          lk_wa = IW'(pending_head);
          lk_wd = free_head;
          st_we = 1'b1;
          st_wa = IW'(pending_head);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers: list heads, totals and response valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      init_idx      <= '0;
      free_head     <= '0;
      pending_head  <= NIL;
      pending_total <= '0;
      active_total  <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_INIT: begin
          init_idx <= init_idx + IW'(1);
        end
        S_ADD: begin
          free_head     <= lk_rd;
          pending_head  <= free_head;
          pending_total <= pending_total + CW'(1);
        end
        S_DISPATCH: begin
          pending_head  <= lk_rd;
          pending_total <= pending_total - CW'(1);
          active_total  <= active_total + CW'(1);
        end
        S_CHECK: begin
          if (func_q == FN_COMPLETE && st_rd == SLOT_ACTIVE) begin
            free_head    <= sid_slot;
            active_total <= active_total - CW'(1);
          end
        end
        S_WALK: begin
          if (walk_hit && walk_prev == NIL) pending_head <= lk_rd;
        end
        S_UNLINK: begin
          free_head     <= sid_slot;
          pending_total <= pending_total - CW'(1);
        end
        S_CLEAR: begin
          if (clear_end) begin
            pending_head  <= NIL;
            pending_total <= '0;
          end else begin
            free_head    <= pending_head;
            pending_head <= lk_rd;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Request capture, walk registers and the result being built.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          func_q     <= req.func;
          sid_q      <= req.slot_id;
          pay_q      <= req.payload;
          res_status <= STAT_OK;
          res_id     <= '0;
          res_pay    <= '0;
          res_free   <= 1'b0;
        end
      end
      S_DECODE: begin
        walk_n <= '0;
        unique case (func_q)
          FN_ADD: begin
            if (free_head == NIL) res_status <= STAT_NO_FREE;
          end
          FN_DISPATCH: begin
            if (pending_head == NIL) res_status <= STAT_NONE_PENDING;
          end
          FN_COMPLETE: begin
            if (!sid_ok) res_status <= STAT_NOT_ACTIVE;
          end
          FN_CANCEL: begin
            if (!sid_ok) res_status <= STAT_NOT_PENDING;
          end
          default: begin
          end
        endcase
      end
      S_ADD: begin
        res_id <= SLOT_ID_W'(free_head);
      end
      S_DISPATCH: begin
        res_id  <= SLOT_ID_W'(pending_head);
        res_pay <= py_rd;
      end
      S_CHECK: begin
        unique case (func_q)
          FN_COMPLETE: begin
            if (st_rd != SLOT_ACTIVE) res_status <= STAT_NOT_ACTIVE;
          end
          FN_CANCEL: begin
            if (st_rd != SLOT_PENDING) begin
              res_status <= STAT_NOT_PENDING;
            end else begin
              walk_cur  <= pending_head;
              walk_prev <= NIL;
            end
          end
          default: begin
            res_free <= (st_rd == SLOT_FREE);
          end
        endcase
      end
      S_WALK: begin
        if (!walk_hit) begin
          if (walk_end) begin
            res_status <= STAT_NOT_PENDING;
          end else begin
            walk_prev <= walk_cur;
            walk_cur  <= lk_rd;
            walk_n    <= walk_n + CW'(1);
          end
        end
      end
      S_CLEAR: begin
        if (!clear_end) walk_n <= walk_n + CW'(1);
      end
      S_DONE: begin
        if (out_load) begin
          out_status   <= res_status;
          out_id       <= res_id;
          out_pay      <= res_pay;
          out_is_free  <= res_free;
          out_free_cnt <= COUNT_W'(WALK_MAX - pending_total - active_total);
          out_pend_cnt <= COUNT_W'(pending_total);
          out_act_cnt  <= COUNT_W'(active_total);
        end
      end
      default: begin
      end
    endcase
  end

  // Response channel.
  assign rsp.valid             = out_valid;
  assign rsp.status            = out_status;
  assign rsp.result_id         = out_id;
  assign rsp.result_payload    = out_pay;
  assign rsp.free_count        = out_free_cnt;
  assign rsp.pending_count_out = out_pend_cnt;
  assign rsp.active_count_out  = out_act_cnt;
  assign rsp.slot_is_free      = out_is_free;

endmodule

`default_nettype wire

// ===== design/jspm_ram.sv =====
// ============================================================================
// jspm_ram
// Simple dual-port memory: one write port and one registered read port.
// ============================================================================
`default_nettype none

module jspm_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
